FILE: rtl/core/rfmf_pkg.sv
`default_nettype none
package rfmf_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;

  // Filter: floor((49*lo + hi) / 50), with lo/hi chosen by direction of change.
  // Division by 50 is a multiply by ceil(2^28 / 50) and a shift by 28, exact for
  // every dividend below 2^22.
  localparam int unsigned MAC_A_W     = 22;
  localparam int unsigned MAC_B_W     = 23;
  localparam int unsigned MAC_RES_W   = 46;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam logic [MAC_B_W-1:0] FILTER_WEIGHT = 23'd49;
  localparam logic [MAC_B_W-1:0] RECIP_MULT    = 23'd5368710;

  typedef enum logic [2:0] {
    PH_HEAD1 = 3'd0,
    PH_HEAD2 = 3'd1,
    PH_DATA  = 3'd2,
    PH_SNR   = 3'd3,
    PH_CHECK = 3'd4
  } rfmf_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL1,
    ST_MUL2,
    ST_OUT
  } rfmf_state_e;

  typedef struct packed {
    logic       take;
    logic       clear;
    logic [7:0] data;
  } rfmf_parse_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/rfmf_in_if.sv
`default_nettype none
interface rfmf_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rfmf_out_if.sv
`default_nettype none
interface rfmf_out_if;
  logic        valid;
  logic        ready;
  logic        reading_valid;
  logic [15:0] filt_range;

  modport source (output valid, output reading_valid, output filt_range, input ready);
  modport sink (input valid, input reading_valid, input filt_range, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rfmf_muladd.sv
`default_nettype none
module rfmf_muladd (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic [rfmf_pkg::MAC_A_W-1:0]   a_i,
  input  wire logic [rfmf_pkg::MAC_B_W-1:0]   b_i,
  input  wire logic [rfmf_pkg::MAC_A_W-1:0]   c_i,
  output logic      [rfmf_pkg::MAC_RES_W-1:0] res_o
);
  import rfmf_pkg::*;

  logic [MAC_RES_W-1:0] res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= MAC_RES_W'(a_i) * MAC_RES_W'(b_i) + MAC_RES_W'(c_i);
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

FILE: rtl/core/rfmf_parser.sv
`default_nettype none
module rfmf_parser #(
  parameter int unsigned NUM_DISTANCES = 5,
  parameter int unsigned NUM_SNR_BYTES = 5
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire rfmf_pkg::rfmf_parse_ctl_t ctl_i,
  input  wire logic [(NUM_DISTANCES > 1 ? $clog2(NUM_DISTANCES) : 1)-1:0] rd_idx_i,
  output logic      [15:0]              rd_word_o,
  output logic                          frame_good_o
);
  import rfmf_pkg::*;

  localparam int unsigned DataBytes = 2 * NUM_DISTANCES;
  localparam int unsigned DcW       = $clog2(DataBytes + 1);
  localparam int unsigned ScW       = (NUM_SNR_BYTES > 0) ? $clog2(NUM_SNR_BYTES + 1) : 1;
  localparam int unsigned WIdxW     = (NUM_DISTANCES > 1) ? $clog2(NUM_DISTANCES) : 1;
  localparam logic [DcW-1:0] DcLast = DcW'(DataBytes - 1);
  localparam logic [ScW-1:0] ScLast = ScW'((NUM_SNR_BYTES > 0) ? NUM_SNR_BYTES - 1 : 0);
  localparam rfmf_phase_e AfterData = (NUM_SNR_BYTES > 0) ? PH_SNR : PH_CHECK;

  rfmf_phase_e    phase_q, phase_d;
  logic [DcW-1:0] dc_q, dc_d;
  logic [ScW-1:0] sc_q, sc_d;
  logic [7:0]     sum_q, sum_d;
  logic           wr_en;
  logic           good;
  logic [15:0]    word_q [NUM_DISTANCES];

  always_comb begin
    phase_d = phase_q;
    dc_d    = dc_q;
    sc_d    = sc_q;
    sum_d   = sum_q;
    wr_en   = 1'b0;
    good    = 1'b0;
    if (ctl_i.clear) begin
      phase_d = PH_HEAD1;
      dc_d    = '0;
      sc_d    = '0;
      sum_d   = '0;
    end else if (ctl_i.take) begin
      case (phase_q)
        PH_HEAD2: begin
          if (ctl_i.data == HEADER_BYTE) begin
            sum_d   = sum_q + HEADER_BYTE;
            dc_d    = '0;
            sc_d    = '0;
            phase_d = PH_DATA;
          end else begin
            phase_d = PH_HEAD1;
          end
        end
        PH_DATA: begin
          wr_en = 1'b1;
          sum_d = sum_q + ctl_i.data;
          dc_d  = dc_q + 1'b1;
          if (dc_q == DcLast) begin
            phase_d = AfterData;
          end
        end
        PH_SNR: begin
          sum_d = sum_q + ctl_i.data;
          sc_d  = sc_q + 1'b1;
          if (sc_q == ScLast) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          good    = (ctl_i.data == sum_q);
          phase_d = PH_HEAD1;
        end
        default: begin
          if (ctl_i.data == HEADER_BYTE) begin
            sum_d   = HEADER_BYTE;
            phase_d = PH_HEAD2;
          end else begin
            phase_d = PH_HEAD1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD1;
      dc_q    <= '0;
      sc_q    <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      dc_q    <= dc_d;
      sc_q    <= sc_d;
      sum_q   <= sum_d;
    end
  end

  // Little-endian: even byte count fills the low half of the word.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (dc_q[0]) begin
        word_q[dc_q[WIdxW:1]][15:8] <= ctl_i.data;
      end else begin
        word_q[dc_q[WIdxW:1]][7:0] <= ctl_i.data;
      end
    end
  end

  assign rd_word_o    = word_q[rd_idx_i];
  assign frame_good_o = good;

endmodule
`default_nettype wire

FILE: rtl/core/ranging_frame_min_filter_unit.sv
`default_nettype none
// Byte item: accepted in ST_IDLE. A byte that closes a frame with a good checksum
// then enters ST_SCAN, one stored distance compared per cycle, NUM_DISTANCES in all.
// Poll item: with a nonzero batch minimum, ST_MUL1 and ST_MUL2 (two passes through the
// shared multiply-add: weighted sum, then reciprocal multiply for /50), then ST_OUT;
// otherwise ST_OUT directly. ST_OUT waits for the sink. One item in flight at a time.
// Reset clears parser, batch minimum, filter state and output; distance store is not cleared.
module ranging_frame_min_filter_unit #(
  parameter int unsigned NUM_DISTANCES = 5,
  parameter int unsigned NUM_SNR_BYTES = 5
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rfmf_in_if.sink   in_i,
  rfmf_out_if.source out_o
);
  import rfmf_pkg::*;

  localparam int unsigned WIdxW = (NUM_DISTANCES > 1) ? $clog2(NUM_DISTANCES) : 1;
  localparam logic [WIdxW-1:0] LastIdx = WIdxW'(NUM_DISTANCES - 1);

  rfmf_state_e      state_q, state_d;
  logic [WIdxW-1:0] idx_q, idx_d;
  logic [15:0]      best_q, best_d;
  logic [15:0]      batch_q, batch_d;
  logic [15:0]      smooth_q, smooth_d;
  logic [15:0]      op_a_q, op_a_d;
  logic [15:0]      op_b_q, op_b_d;
  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  logic             rep_valid_q, rep_valid_d;
  logic [15:0]      rep_dist_q, rep_dist_d;

  logic             in_acc;
  logic             frame_good;
  logic [15:0]      rd_word;
  logic [15:0]      best_n;
  logic [15:0]      seed;
  logic [15:0]      quot;
  logic             out_free;
  rfmf_parse_ctl_t  pctl;

  logic                 mac_en;
  logic [MAC_A_W-1:0]   mac_a;
  logic [MAC_B_W-1:0]   mac_b;
  logic [MAC_A_W-1:0]   mac_c;
  logic [MAC_RES_W-1:0] mac_res;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign pctl.take  = in_acc && !in_i.req_type;
  assign pctl.clear = in_acc && in_i.req_type;
  assign pctl.data  = in_i.rx_byte;

  rfmf_parser #(
    .NUM_DISTANCES(NUM_DISTANCES),
    .NUM_SNR_BYTES(NUM_SNR_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (pctl),
    .rd_idx_i    (idx_q),
    .rd_word_o   (rd_word),
    .frame_good_o(frame_good)
  );

  rfmf_muladd u_mac (
    .clk_i(clk_i),
    .en_i (mac_en),
    .a_i  (mac_a),
    .b_i  (mac_b),
    .c_i  (mac_c),
    .res_o(mac_res)
  );

  assign best_n = ((rd_word != 16'd0) && ((best_q == 16'd0) || (rd_word < best_q)))
                  ? rd_word : best_q;
  assign seed   = (smooth_q == 16'd0) ? batch_q : smooth_q;
  assign quot   = mac_res[RECIP_SHIFT +: 16];

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    best_d      = best_q;
    batch_d     = batch_q;
    smooth_d    = smooth_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    rep_valid_d = rep_valid_q;
    rep_dist_d  = rep_dist_q;
    mac_en      = 1'b0;
    mac_a       = MAC_A_W'(op_a_q);
    mac_b       = FILTER_WEIGHT;
    mac_c       = MAC_A_W'(op_b_q);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.req_type) begin
            batch_d = 16'd0;
            if (batch_q == 16'd0) begin
              pend_d  = 1'b0;
              state_d = ST_OUT;
            end else begin
              // Seed on first use; lower value takes the weight of 49.
              pend_d   = 1'b1;
              smooth_d = seed;
              if (batch_q <= seed) begin
                op_a_d = batch_q;
                op_b_d = seed;
              end else begin
                op_a_d = seed;
                op_b_d = batch_q;
              end
              state_d = ST_MUL1;
            end
          end else if (frame_good) begin
            idx_d   = '0;
            best_d  = 16'd0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        best_d = best_n;
        if (idx_q == LastIdx) begin
          if ((best_n != 16'd0) && ((batch_q == 16'd0) || (best_n < batch_q))) begin
            batch_d = best_n;
          end
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_MUL1: begin
        mac_en  = 1'b1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        mac_en  = 1'b1;
        mac_a   = mac_res[MAC_A_W-1:0];
        mac_b   = RECIP_MULT;
        mac_c   = '0;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rep_valid_d = pend_q;
          if (pend_q) begin
            rep_dist_d = quot;
            smooth_d   = quot;
          end else begin
            rep_dist_d = 16'd0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      batch_q     <= 16'd0;
      smooth_q    <= 16'd0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      batch_q     <= batch_d;
      smooth_q    <= smooth_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q      <= best_d;
    op_a_q      <= op_a_d;
    op_b_q      <= op_b_d;
    rep_valid_q <= rep_valid_d;
    rep_dist_q  <= rep_dist_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.reading_valid = rep_valid_q;
  assign out_o.filt_range    = rep_dist_q;

`ifndef ASSERT_OFF
  a_poll_clears_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.req_type) |=> (batch_q == 16'd0))
    else $error("batch minimum not cleared by poll");

  a_filter_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && pend_q) |-> (quot >= op_a_q && quot <= op_b_q))
    else $error("filtered value outside old/new range");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) |-> (idx_q == '0))
    else $error("scan index left nonzero outside scan");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rep_valid_q) |-> (rep_dist_q == 16'd0))
    else $error("invalid reading carries nonzero distance");
`endif

endmodule
`default_nettype wire
